// ----- rtl/sequential_list_engine_defines.svh -----
// assertion macros for the sequential list engine checker
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sle_pkg.sv -----
// shared constants for the sequential list engine
package sle_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ERASE      = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_FIND       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

// ----- rtl/sle_channels.sv -----
// request and result channel interfaces for the sequential list engine
interface sle_in_if;
    logic                                valid;
    logic                                ready;
    logic        [sle_pkg::ACTION_W-1:0] action;
    logic        [sle_pkg::POS_W-1:0]    position;
    logic signed [sle_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface sle_out_if;
    logic                         valid;
    logic                         ready;
    logic [sle_pkg::STATUS_W-1:0] status;
    logic                         hit;
    logic [sle_pkg::INDEX_W-1:0]  hit_index;
    logic [sle_pkg::COUNT_W-1:0]  count_now;

    modport source (output valid, output status, output hit, output hit_index,
                    output count_now, input ready);
    modport sink   (input valid, input status, input hit, input hit_index,
                    input count_now, output ready);
endinterface

// ----- rtl/sle_ram.sv -----
// generic single-write, single-read ram with registered read data
module sle_ram #(
    parameter int WIDTH = sle_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = sle_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sequential_list_engine.sv -----
// sequential list engine top level: sequencer, shift and search around one ram
// pushes, pops, insert and erase shift the moved entries through the ram; errors skip the walk
// find walks from index 0 to the first hit or the end of the list; an empty list skips the walk
// one item at a time: the shift/search walk through the ram, one entry a cycle, and result back-pressure set the rate
// a result may wait in the output register
// synchronous active-low reset empties the list; store contents stay undefined
module sequential_list_engine #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sle_in_if.sink     i_in,
    sle_out_if.source  o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_DOWN = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [AW-1:0]                  r_last, n_last;
    logic [AW-1:0]                  r_at, n_at;
    logic                           r_rd_busy, n_rd_busy;
    logic                           r_dat_pend, n_dat_pend;
    logic [AW-1:0]                  r_dat_addr, n_dat_addr;
    logic [DATA_WIDTH-1:0]          r_key, n_key;
    logic [sle_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic                           r_res_hit, n_res_hit;
    logic [AW-1:0]                  r_res_idx, n_res_idx;
    logic                           r_out_valid, n_out_valid;
    logic [sle_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic                           r_out_hit, n_out_hit;
    logic [sle_pkg::INDEX_W-1:0]    r_out_idx, n_out_idx;
    logic [sle_pkg::COUNT_W-1:0]    r_out_count, n_out_count;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_wa, ram_ra;
    logic [DATA_WIDTH-1:0] ram_wd, ram_rdata;

    logic [DATA_WIDTH-1:0] in_value;
    logic [PW-1:0]         cnt_p, pos_p, at_p;
    logic [AW-1:0]         cnt_m1;
    logic                  full, empty, go_up, go_down;

    assign in_value = DATA_WIDTH'(i_in.value);
    assign cnt_p    = PW'(r_count);
    assign pos_p    = PW'(i_in.position);
    assign cnt_m1   = AW'(r_count - CW'(1));
    assign full     = cnt_p >= PW'(CAPACITY);
    assign empty    = (r_count == '0);

    sle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_last       = r_last;
        n_at         = r_at;
        n_rd_busy    = r_rd_busy;
        n_dat_pend   = r_dat_pend;
        n_dat_addr   = r_dat_addr;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_res_idx    = r_res_idx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_hit    = r_out_hit;
        n_out_idx    = r_out_idx;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_wa       = r_dat_addr;
        ram_wd       = ram_rdata;
        ram_re       = 1'b0;
        ram_ra       = r_addr;
        go_up        = 1'b0;
        go_down      = 1'b0;
        at_p         = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // shared walk: one read a cycle, data used in the next cycle
        if ((r_state == S_UP) || (r_state == S_DOWN) || (r_state == S_FIND)) begin
            if (r_rd_busy) begin
                ram_re     = 1'b1;
                n_dat_pend = 1'b1;
                case (r_state)
                    S_UP:    n_dat_addr = r_addr + AW'(1);
                    S_DOWN:  n_dat_addr = r_addr - AW'(1);
                    default: n_dat_addr = r_addr;
                endcase
                if (r_addr == r_last) begin
                    n_rd_busy = 1'b0;
                end else if (r_state == S_UP) begin
                    n_addr = r_addr - AW'(1);
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end else begin
                n_dat_pend = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res_status = sle_pkg::ST_OK;
                    n_res_hit    = 1'b0;
                    n_res_idx    = '0;
                    n_key        = in_value;
                    n_state      = S_HOLD;
                    case (i_in.action)
                        sle_pkg::ACT_PUSH_BACK,
                        sle_pkg::ACT_PUSH_FRONT: begin
                            if (full) begin
                                n_res_status = sle_pkg::ST_FULL;
                            end else begin
                                go_up = 1'b1;
                                at_p  = (i_in.action == sle_pkg::ACT_PUSH_BACK) ? cnt_p : '0;
                            end
                        end
                        sle_pkg::ACT_POP_FRONT,
                        sle_pkg::ACT_POP_BACK: begin
                            if (empty) begin
                                n_res_status = sle_pkg::ST_EMPTY;
                            end else begin
                                go_down = 1'b1;
                                at_p    = (i_in.action == sle_pkg::ACT_POP_FRONT) ?
                                          '0 : (cnt_p - PW'(1));
                            end
                        end
                        sle_pkg::ACT_INSERT: begin
                            if (pos_p > cnt_p) begin
                                n_res_status = sle_pkg::ST_RANGE;
                            end else if (full) begin
                                n_res_status = sle_pkg::ST_FULL;
                            end else begin
                                go_up = 1'b1;
                                at_p  = pos_p;
                            end
                        end
                        sle_pkg::ACT_ERASE: begin
                            if (empty) begin
                                n_res_status = sle_pkg::ST_EMPTY;
                            end else if (pos_p >= cnt_p) begin
                                n_res_status = sle_pkg::ST_RANGE;
                            end else begin
                                go_down = 1'b1;
                                at_p    = pos_p;
                            end
                        end
                        sle_pkg::ACT_FIND: begin
                            if (!empty) begin
                                n_state    = S_FIND;
                                n_addr     = '0;
                                n_last     = cnt_m1;
                                n_rd_busy  = 1'b1;
                                n_dat_pend = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (go_up) begin
                        n_state    = S_UP;
                        n_at       = AW'(at_p);
                        n_addr     = cnt_m1;
                        n_last     = AW'(at_p);
                        n_rd_busy  = cnt_p > at_p;
                        n_dat_pend = 1'b0;
                    end
                    if (go_down) begin
                        n_state    = S_DOWN;
                        n_at       = AW'(at_p);
                        n_addr     = AW'(at_p + PW'(1));
                        n_last     = cnt_m1;
                        n_rd_busy  = (cnt_p - PW'(1)) > at_p;
                        n_dat_pend = 1'b0;
                    end
                end
            end
            S_UP: begin
                if (r_dat_pend) begin
                    ram_we = 1'b1;
                end else if (!r_rd_busy) begin
                    ram_we  = 1'b1;
                    ram_wa  = r_at;
                    ram_wd  = r_key;
                    n_count = r_count + CW'(1);
                    n_state = S_HOLD;
                end
            end
            S_DOWN: begin
                if (r_dat_pend) begin
                    ram_we = 1'b1;
                end else if (!r_rd_busy) begin
                    n_count = r_count - CW'(1);
                    n_state = S_HOLD;
                end
            end
            S_FIND: begin
                if (r_dat_pend && (ram_rdata == r_key)) begin
                    n_res_hit  = 1'b1;
                    n_res_idx  = r_dat_addr;
                    n_rd_busy  = 1'b0;
                    n_dat_pend = 1'b0;
                    n_state    = S_HOLD;
                end else if (r_dat_pend && !r_rd_busy) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_hit    = r_res_hit;
                    n_out_idx    = sle_pkg::INDEX_W'(r_res_idx);
                    n_out_count  = sle_pkg::COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_busy   <= 1'b0;
            r_dat_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_busy   <= n_rd_busy;
            r_dat_pend  <= n_dat_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_last       <= n_last;
        r_at         <= n_at;
        r_dat_addr   <= n_dat_addr;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_res_idx    <= n_res_idx;
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
        r_out_idx    <= n_out_idx;
        r_out_count  <= n_out_count;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.hit       = r_out_hit;
    assign o_out.hit_index = r_out_idx;
    assign o_out.count_now = r_out_count;

endmodule

// ----- rtl/sle_checker.sv -----
// port-level assertion checker for the sequential list engine, with its bind
`include "sequential_list_engine_defines.svh"

module sle_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [sle_pkg::STATUS_W-1:0] i_out_status,
    input logic                         i_out_hit,
    input logic [sle_pkg::INDEX_W-1:0]  i_out_hit_index,
    input logic [sle_pkg::COUNT_W-1:0]  i_out_count_now
);

    `SLE_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_status) && $stable(i_out_hit) && $stable(i_out_hit_index) && $stable(i_out_count_now),
        "stalled result changed")
    `SLE_ASSERT_NXT(a_busy_after_in, i_in_valid && i_in_ready, !i_in_ready,
        "engine ready straight after an input transfer")
    `SLE_ASSERT_IMP(a_hit_ok, i_out_valid && i_out_hit, i_out_status == sle_pkg::ST_OK,
        "hit reported with an error status")
    `SLE_ASSERT_IMP(a_miss_index, i_out_valid && !i_out_hit, i_out_hit_index == '0,
        "non-zero index without a hit")

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_status    (o_out.status),
    .i_out_hit       (o_out.hit),
    .i_out_hit_index (o_out.hit_index),
    .i_out_count_now (o_out.count_now)
);

// ----- bench/list_result_checker.sv -----
// result checker for the sequential list engine: mirrors the list and compares every result
module list_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sle_in_if    i_req,
    sle_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);
    import sle_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [INDEX_W-1:0]  hit_index;
        logic [COUNT_W-1:0]  count_now;
    } list_result_t;

    logic [VALUE_W-1:0] held_values [CAPACITY_DEF];
    int                 held_count;
    list_result_t       pending_results [$];

    function automatic void open_slot(int at, logic [VALUE_W-1:0] v);
        for (int k = held_count; k > at; k--) held_values[k] = held_values[k - 1];
        held_values[at] = v;
        held_count++;
    endfunction

    function automatic void close_slot(int at);
        for (int k = at; k + 1 < held_count; k++) held_values[k] = held_values[k + 1];
        held_count--;
    endfunction

    function automatic list_result_t apply_request(logic [ACTION_W-1:0] act,
                                                   logic [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] v);
        list_result_t r;
        r = '0;
        case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                if (held_count >= CAPACITY_DEF) r.status = ST_FULL;
                else open_slot(act == ACT_PUSH_BACK ? held_count : 0, v);
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (held_count == 0) r.status = ST_EMPTY;
                else close_slot(act == ACT_POP_FRONT ? 0 : held_count - 1);
            end
            ACT_INSERT: begin
                // range check comes before the full check
                if (int'(pos) > held_count) r.status = ST_RANGE;
                else if (held_count >= CAPACITY_DEF) r.status = ST_FULL;
                else open_slot(int'(pos), v);
            end
            ACT_ERASE: begin
                if (held_count == 0) r.status = ST_EMPTY;
                else if (int'(pos) >= held_count) r.status = ST_RANGE;
                else close_slot(int'(pos));
            end
            ACT_FIND: begin
                for (int k = 0; k < held_count; k++) begin
                    if (!r.hit && held_values[k] == v) begin
                        r.hit       = 1'b1;
                        r.hit_index = INDEX_W'(k);
                    end
                end
            end
            default: ;
        endcase
        r.count_now = COUNT_W'(held_count);
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        list_result_t want;
        if (!i_rst_n) begin
            held_count = 0;
            pending_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                pending_results.push_back(apply_request(i_req.action, i_req.position, i_req.value));
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, got status %0d count %0d",
                             $time, i_rsp.status, i_rsp.count_now);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("hit", want.hit, i_rsp.hit);
                    check_field("hit_index", want.hit_index, i_rsp.hit_index);
                    check_field("count_now", want.count_now, i_rsp.count_now);
                end
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

// ----- bench/testbench.sv -----
// top of the sequential list engine bench: clock, reset, request and result traffic, verdict
module testbench;
    import sle_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int RANDOM_ITEMS = 1030;
    localparam int PHASE_LEN    = 80;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [VALUE_W-1:0]  CORNER_VALUES [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   results_seen;
    bit   sender_quiet;

    sle_in_if  req_ch ();
    sle_out_if rsp_ch ();

    sequential_list_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    list_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // one request transfer, starting and ending at a falling edge
    task automatic send_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] v);
        int gap;
        gap = sender_quiet ? 0 : gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.value    <= v;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk)
        if (rsp_ch.valid && rsp_ch.ready) results_seen++;

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin
        int stall_left;
        bit held_off;
        stall_left = 0;
        held_off   = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off   = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && ((results_seen / 128) % 3) != 2
                         && $urandom_range(0, 4) == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        mix_t                mix;
        mix_t                phase_plan [6];
        int                  r;
        int                  growth;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;

        phase_plan = '{MIX_GROW, MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_SHRINK, MIX_BALANCED};
        sender_quiet    = 1'b0;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_PUSH_BACK;
        req_ch.position = '0;
        req_ch.value    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corners
        send_request(ACT_FIND, 7'd0, 32'h0);
        send_request(ACT_POP_FRONT, 7'd0, 32'h0);
        send_request(ACT_POP_BACK, 7'd0, 32'h0);
        send_request(ACT_ERASE, 7'd0, 32'h0);
        send_request(ACT_INSERT, 7'd1, 32'h1);
        send_request(ACT_INSERT, 7'd127, 32'h1);
        // value extremes, duplicates
        send_request(ACT_INSERT, 7'd0, 32'h8000_0000);
        send_request(ACT_PUSH_BACK, 7'd0, 32'h7FFF_FFFF);
        send_request(ACT_PUSH_FRONT, 7'd0, 32'hFFFF_FFFF);
        send_request(ACT_PUSH_BACK, 7'd0, 32'h0);
        send_request(ACT_PUSH_BACK, 7'd0, 32'h7FFF_FFFF);
        send_request(ACT_FIND, 7'd0, 32'h7FFF_FFFF);
        send_request(ACT_FIND, 7'd0, 32'h1234_5678);
        // position at and past the end
        send_request(ACT_INSERT, 7'd5, 32'h5);
        send_request(ACT_INSERT, 7'd7, 32'h7);
        send_request(ACT_ERASE, 7'd6, 32'h0);
        send_request(ACT_ERASE, 7'd2, 32'h0);
        send_request(ACT_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_request(ACT_POP_FRONT, 7'd0, 32'h0);
        send_request(ACT_POP_BACK, 7'd0, 32'h0);
        send_request(ACT_FIND, 7'd0, 32'hFFFF_FFFF);
        send_request(ACT_ERASE, 7'd127, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sender_quiet = ((i / 150) % 3) == 1;
            mix    = phase_plan[(i / PHASE_LEN) % 6];
            growth = (mix == MIX_GROW) ? 90 : (mix == MIX_SHRINK) ? 10 : 50;

            r = $urandom_range(0, 99);
            if (r < 14) begin
                act = ACT_FIND;
            end else if (r < 15) begin
                act = ACT_UNUSED;
            end else if ($urandom_range(0, 99) < growth) begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_PUSH_BACK;
                    1:       act = ACT_PUSH_FRONT;
                    default: act = ACT_INSERT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_POP_FRONT;
                    1:       act = ACT_POP_BACK;
                    default: act = ACT_ERASE;
                endcase
            end

            r = $urandom_range(0, 99);
            if (r < 70)      pos = POS_W'($urandom_range(0, CAPACITY_DEF));
            else if (r < 82) pos = '0;
            else if (r < 94) pos = POS_W'($urandom_range(0, 7));
            else             pos = POS_W'($urandom_range(0, 127));

            // small pool keeps finds hitting and duplicates common
            r = $urandom_range(0, 99);
            if (r < 50)      val = VALUE_W'($urandom_range(0, 15));
            else if (r < 60) val = CORNER_VALUES[$urandom_range(0, 3)];
            else             val = $urandom;

            send_request(act, pos, val);
        end
        req_ch.valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
